FILE: hdl/bffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bitmap first-fit block allocator: field
// widths, command and status codes, and the layout of one bitmap row.
// ----------------------------------------------------------------------------
package bffa_pkg;

    // parameter defaults
    localparam int BLOCK_BYTES_DEF = 16;
    localparam int NUM_BLOCKS_DEF  = 1024;

    // one bitmap row holds this many blocks
    localparam int WORD_BITS  = 8;
    localparam int WORD_SHIFT = $clog2(WORD_BITS);

    // item field widths
    localparam int SIZE_W = 15;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;

    // ceiling divider: dividend is size plus the rounding term
    localparam int DIVD_W = 16;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_NOSPACE = 1'b1;

    // one row of the bitmap: used bits and continues-to-next bits
    typedef struct packed {
        logic [WORD_BITS-1:0] used;
        logic [WORD_BITS-1:0] cont;
    } t_row;

endpackage

FILE: hdl/bffa_ceil_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_ceil_div
// Turns a byte size into a block count, rounding up. The rounded-up dividend
// is registered, then multiplied by a fixed reciprocal of the block size;
// the product is registered as the quotient, with done raised alongside it.
// ----------------------------------------------------------------------------
module bffa_ceil_div #(
    parameter int BLOCK_BYTES = bffa_pkg::BLOCK_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bffa_pkg::SIZE_W-1:0] i_size,
    output logic                        o_done,
    output logic [bffa_pkg::DIVD_W-1:0] o_quot
);

    localparam int DW  = bffa_pkg::DIVD_W;
    localparam int LG  = $clog2(BLOCK_BYTES);
    localparam int SH  = DW + LG;
    localparam int MW  = DW + 1;
    localparam int PRW = DW + MW;
    localparam longint SCALE = longint'(1) << SH;
    localparam logic [MW-1:0] RECIP =
        MW'((SCALE + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES));
    localparam logic [DW-1:0] ROUND = DW'(BLOCK_BYTES - 1);

    logic           r_pend;
    logic           r_done;
    logic [DW-1:0]  r_divd;
    logic [DW-1:0]  r_quot;
    logic [PRW-1:0] prod;

    // reciprocal multiply, exact for every dividend below 2**DW because the
    // rounding error of the reciprocal stays below 2**LG
    assign prod = {{MW{1'b0}}, r_divd} * {{DW{1'b0}}, RECIP};

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pend <= i_start;
            r_done <= r_pend;
        end
    end

    // dividend capture and quotient register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divd <= DW'(i_size) + ROUND;
        end
        if (r_pend) begin
            r_quot <= DW'(prod >> SH);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hdl/bffa_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bffa_map_ram
// Bitmap store: one row of used and continuation bits per entry, one write
// port and one registered read port. A read of the row written in the same
// cycle returns the old contents; the controller issues such reads only where it ignores the data.
// ----------------------------------------------------------------------------
module bffa_map_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  bffa_pkg::t_row       i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output bffa_pkg::t_row       o_rdata
);

    bffa_pkg::t_row r_mem [DEPTH];
    bffa_pkg::t_row r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bitmap_first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_top
// First-fit block allocator over a used/continuation bitmap held in a
// synchronous RAM, eight blocks per row.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// o_status, o_run_head and o_block_count for exactly one cycle, flagged by
// o_valid, in the cycle busy falls, and must be captured then: the receiver
// has no way to stall it. After reset the block clears every row of the
// bitmap RAM with busy high. An allocate first waits for the ceiling divider,
// then scans one RAM row per cycle from block 0 (at most NUM_BLOCKS/8 rows),
// reloads the first row of the run and marks each row the run covers.
// Zero-size and oversized requests finish as soon as the divider is done.
// A free walks each row its run touches, stopping at the last row; a free
// start beyond the last block is answered in the next cycle, with busy
// staying low.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator_top #(
    parameter int BLOCK_BYTES = bffa_pkg::BLOCK_BYTES_DEF,
    parameter int NUM_BLOCKS  = bffa_pkg::NUM_BLOCKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [bffa_pkg::SIZE_W-1:0] i_size_bytes,
    input  logic [bffa_pkg::IDX_W-1:0]  i_start_block,
    output logic                        o_valid,
    output logic                        o_status,
    output logic [bffa_pkg::IDX_W-1:0]  o_run_head,
    output logic [bffa_pkg::CNT_W-1:0]  o_block_count
);

    localparam int WB  = bffa_pkg::WORD_BITS;
    localparam int WS  = bffa_pkg::WORD_SHIFT;
    localparam int IW  = bffa_pkg::IDX_W;
    localparam int OCW = bffa_pkg::CNT_W;
    localparam int DW  = bffa_pkg::DIVD_W;
    localparam int NR  = (NUM_BLOCKS + WB - 1) / WB;
    localparam int RW  = (NR > 1) ? $clog2(NR) : 1;
    localparam int PW  = RW + WS;
    localparam int BW  = $clog2(NUM_BLOCKS);
    localparam int CW  = BW + 1;
    localparam logic [RW-1:0] LAST_ROW = RW'(NR - 1);
    localparam logic [PW:0]   NB       = (PW + 1)'(NUM_BLOCKS);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_MARK  = 7'b0100000,
        S_FREE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_run, n_run;
    logic [CW-1:0] r_need, n_need;
    logic [PW-1:0] r_first, n_first;
    logic [PW-1:0] r_end, n_end;
    logic [PW-1:0] r_start_pos, n_start_pos;
    logic [IW-1:0] r_start_idx, n_start_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_valid, n_valid;
    logic          r_status, n_status;
    logic [IW-1:0] r_index, n_index;
    logic [OCW-1:0] r_out_count, n_out_count;

    // divider and ram hookup
    logic                 div_start;
    logic                 div_done;
    logic [DW-1:0]        div_quot;
    logic                 ram_we;
    logic [RW-1:0]        ram_waddr;
    bffa_pkg::t_row       ram_wdata;
    logic [RW-1:0]        ram_raddr;
    bffa_pkg::t_row       ram_rdata;

    bffa_ceil_div #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_size  (i_size_bytes),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    bffa_map_ram #(
        .DEPTH (NR),
        .AW    (RW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // width conversions of request and result values
    logic [PW+IW-1:0]  start_wide;
    logic [PW-1:0]     start_pos;
    logic              start_in_range;
    logic [CW+DW-1:0]  need_wide;
    logic [CW-1:0]     quot_need;
    logic              quot_too_big;
    logic [IW+PW-1:0]  first_wide;
    logic [IW-1:0]     first_idx;
    logic [OCW+CW-1:0] need_out_wide;
    logic [OCW-1:0]    need_out;
    logic [OCW+CW-1:0] free_out_wide;
    logic [OCW-1:0]    free_out;

    assign start_wide     = {{PW{1'b0}}, i_start_block};
    assign start_pos      = start_wide[PW-1:0];
    assign start_in_range = (32'(i_start_block) < 32'(NUM_BLOCKS));
    assign need_wide      = {{CW{1'b0}}, div_quot};
    assign quot_need      = need_wide[CW-1:0];
    assign quot_too_big   = (32'(div_quot) > 32'(NUM_BLOCKS));
    assign first_wide     = {{IW{1'b0}}, r_first};
    assign first_idx      = first_wide[IW-1:0];
    assign need_out_wide  = {{OCW{1'b0}}, r_need};
    assign need_out       = need_out_wide[OCW-1:0];

    // scan of one row: extend the free run, find where it reaches the need
    logic [CW-1:0]    scan_run;
    logic             scan_hit;
    logic [WS-1:0]    scan_bit;
    logic [PW-1:0]    scan_end;
    logic [PW+CW-1:0] scan_first_wide;
    logic [PW-1:0]    scan_first;

    always_comb begin
        logic [PW-1:0] pos;
        scan_run = r_run;
        scan_hit = 1'b0;
        scan_bit = '0;
        for (int j = 0; j < WB; j++) begin
            pos = {r_row, WS'(j)};
            if (ram_rdata.used[j] || ({1'b0, pos} >= NB)) begin
                scan_run = '0;
            end else begin
                scan_run = CW'(scan_run + 1'b1);
            end
            if (!scan_hit && (scan_run == r_need)) begin
                scan_hit = 1'b1;
                scan_bit = WS'(j);
            end
        end
    end

    assign scan_end        = {r_row, scan_bit};
    assign scan_first_wide = {{CW{1'b0}}, scan_end} + (PW + CW)'(1) - {{PW{1'b0}}, r_need};
    assign scan_first      = scan_first_wide[PW-1:0];

    // marking of one row of the new run
    bffa_pkg::t_row mark_row;

    always_comb begin
        logic [PW-1:0] pos;
        logic          in_run;
        for (int j = 0; j < WB; j++) begin
            pos    = {r_row, WS'(j)};
            in_run = (pos >= r_first) && (pos <= r_end);
            mark_row.used[j] = ram_rdata.used[j] | in_run;
            mark_row.cont[j] = in_run ? (pos != r_end) : ram_rdata.cont[j];
        end
    end

    // free walk over one row
    bffa_pkg::t_row free_row;
    logic [CW-1:0]  free_cnt;
    logic           free_more;
    logic           free_done;

    always_comb begin
        logic [PW-1:0] pos;
        logic          act;
        free_more = 1'b1;
        free_cnt  = r_count;
        for (int j = 0; j < WB; j++) begin
            pos = {r_row, WS'(j)};
            act = free_more && (pos >= r_start_pos) && ({1'b0, pos} < NB);
            free_row.used[j] = act ? 1'b0 : ram_rdata.used[j];
            free_row.cont[j] = act ? 1'b0 : ram_rdata.cont[j];
            if (act) begin
                free_cnt = CW'(free_cnt + 1'b1);
                if (!ram_rdata.cont[j]) begin
                    free_more = 1'b0;
                end
            end
        end
    end

    assign free_done     = !free_more || (r_row == LAST_ROW);
    assign free_out_wide = {{OCW{1'b0}}, free_cnt};
    assign free_out      = free_out_wide[OCW-1:0];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_run       = r_run;
        n_need      = r_need;
        n_first     = r_first;
        n_end       = r_end;
        n_start_pos = r_start_pos;
        n_start_idx = r_start_idx;
        n_count     = r_count;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_index     = r_index;
        n_out_count = r_out_count;
        div_start   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_row;
        ram_wdata   = '0;
        ram_raddr   = r_row;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_row = RW'(r_row + 1'b1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_command == bffa_pkg::CMD_ALLOC) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else if (start_in_range) begin
                        n_start_pos = start_pos;
                        n_start_idx = i_start_block;
                        n_row       = start_pos[PW-1:WS];
                        ram_raddr   = start_pos[PW-1:WS];
                        n_count     = '0;
                        n_state     = S_FREE;
                    end else begin
                        n_valid     = 1'b1;
                        n_status    = bffa_pkg::ST_OK;
                        n_index     = i_start_block;
                        n_out_count = '0;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (div_quot == '0) begin
                        n_valid     = 1'b1;
                        n_status    = bffa_pkg::ST_OK;
                        n_index     = '0;
                        n_out_count = '0;
                        n_state     = S_IDLE;
                    end else if (quot_too_big) begin
                        n_valid     = 1'b1;
                        n_status    = bffa_pkg::ST_NOSPACE;
                        n_index     = '0;
                        n_out_count = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_need    = quot_need;
                        n_run     = '0;
                        n_row     = '0;
                        ram_raddr = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_run     = scan_run;
                ram_raddr = (r_row == LAST_ROW) ? r_row : RW'(r_row + 1'b1);
                n_row     = (r_row == LAST_ROW) ? r_row : RW'(r_row + 1'b1);
                if (scan_hit) begin
                    n_end   = scan_end;
                    n_first = scan_first;
                    n_row   = scan_first[PW-1:WS];
                    n_state = S_LOAD;
                end else if (r_row == LAST_ROW) begin
                    n_valid     = 1'b1;
                    n_status    = bffa_pkg::ST_NOSPACE;
                    n_index     = '0;
                    n_out_count = '0;
                    n_state     = S_IDLE;
                end
            end
            S_LOAD: begin
                ram_raddr = r_row;
                n_state   = S_MARK;
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = mark_row;
                if (r_row == r_end[PW-1:WS]) begin
                    n_valid     = 1'b1;
                    n_status    = bffa_pkg::ST_OK;
                    n_index     = first_idx;
                    n_out_count = need_out;
                    n_state     = S_IDLE;
                end else begin
                    n_row     = RW'(r_row + 1'b1);
                    ram_raddr = RW'(r_row + 1'b1);
                end
            end
            S_FREE: begin
                ram_we    = 1'b1;
                ram_wdata = free_row;
                n_count   = free_cnt;
                if (free_done) begin
                    n_valid     = 1'b1;
                    n_status    = bffa_pkg::ST_OK;
                    n_index     = r_start_idx;
                    n_out_count = free_out;
                    n_state     = S_IDLE;
                end else begin
                    n_row     = RW'(r_row + 1'b1);
                    ram_raddr = RW'(r_row + 1'b1);
                end
            end
            default: begin
                n_row   = '0;
                n_state = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_valid <= n_valid;
        end
    end

    // request context and result registers
    always_ff @(posedge i_clk) begin
        r_run       <= n_run;
        r_need      <= n_need;
        r_first     <= n_first;
        r_end       <= n_end;
        r_start_pos <= n_start_pos;
        r_start_idx <= n_start_idx;
        r_count     <= n_count;
        r_status    <= n_status;
        r_index     <= n_index;
        r_out_count <= n_out_count;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_run_head    = r_index;
    assign o_block_count = r_out_count;

`ifndef SYNTHESIS
    // a result only shows once the walk or scan has handed back control
    a_valid_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    // the divider finishes only while its quotient is awaited
    a_div_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    // a refused allocate reports nothing else
    a_nospace_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bffa_pkg::ST_NOSPACE)) |->
        ((o_run_head == '0) && (o_block_count == '0)))
        else $error("no-space result with nonzero index or count");

    // marking writes only rows that the new run covers
    a_mark_rows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == S_MARK)) |->
        ((r_row >= r_first[PW-1:WS]) && (r_row <= r_end[PW-1:WS])))
        else $error("mark write outside the run");
`endif

endmodule
